[src/rdb_pkg.sv]
// rdb_pkg: shared sizes, command and status codes, and the command word type
// used between the front and back parts of reversible_deque_buffer
// no dependencies
package rdb_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 16;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 16;
  localparam int ELEM_W     = 16;
  localparam int STAT_W     = 2;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_REV  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_FIN  = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ELEM  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERR   = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_READ,
    BK_CAPT
  } back_state_e;

  typedef struct packed {
    mode_e                op;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  // circular index: head plus offset, both below DEPTH
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[src/rdb_if.sv]
// rdb_in_if and rdb_out_if: valid/ready channels for command words and result words
// depends on rdb_pkg
interface rdb_in_if import rdb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface rdb_out_if import rdb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

[src/reversible_deque_buffer.sv]
// channel   dir  fields                        word
// in_i      in   mode[1:0], value[15:0]        one command
// out_o     out  element[15:0], status[1:0],   one result
//                last
//
// load, reverse and delete act in the back part's run state; the two-word
// command queue takes input while the back part is busy
// finish drains each element via read and capture states (store read port,
// registered read) or gives one status word; queued commands wait meanwhile
// a stalled output holds its word and the drain waits on it
// reset clears pointers, count and flags; the store needs no clearing
// top level: reversible_deque_buffer, built from rdb_front and rdb_back
// depends on rdb_pkg and rdb_if
module reversible_deque_buffer import rdb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdb_in_if.sink    in_i,
  rdb_out_if.source out_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  rdb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  rdb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

[src/rdb_ram.sv]
// rdb_ram: generic single write port, single read port ram with registered read
// no dependencies
module rdb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/rdb_front.sv]
// rdb_front: takes command words, decodes the mode and queues them for the back part
// depends on rdb_pkg and rdb_in_if
module rdb_front import rdb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  rdb_in_if.sink   in_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_ready_i
);

  cmd_t              q_mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              dec;

  always_comb begin
    dec.value = in_i.value;
    case (in_i.mode)
      MODE_LOAD: dec.op = MODE_LOAD;
      MODE_REV:  dec.op = MODE_REV;
      MODE_DEL:  dec.op = MODE_DEL;
      default:   dec.op = MODE_FIN;
    endcase
  end

  assign in_i.ready  = (cnt_q != QCNT_W'(QDEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= dec;
    end
  end

endmodule

[src/rdb_back.sv]
// rdb_back: executes queued commands on the circular store and drains it on finish
// depends on rdb_pkg, rdb_out_if and rdb_ram
module rdb_back import rdb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  rdb_out_if.source out_o
);

  back_state_e          state_q, state_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 rev_q, rev_d;
  logic                 err_q, err_d;
  logic                 ovf_q, ovf_d;
  logic [PTR_W-1:0]     idx_q, idx_d;
  logic                 out_valid_q;
  logic [ELEM_W-1:0]    out_elem_q, out_elem_d;
  status_e              out_stat_q, out_stat_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load, out_free, is_last;
  logic [PTR_W-1:0]     pos;
  logic [CNT_W-1:0]     cnt_m1;
  logic                 we, re;
  logic [PTR_W-1:0]     waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;

  rdb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (DATA_WIDTH'(cmd_i.value)),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_m1   = cnt_q - CNT_W'(1);
  // logical position k maps to count-1-k while reversed
  assign pos      = rev_q ? cnt_m1[PTR_W-1:0] - idx_q : idx_q;
  assign is_last  = (CNT_W'(idx_q) + CNT_W'(1) == cnt_q);
  assign waddr    = phys(head_q, cnt_q[PTR_W-1:0]);
  assign raddr    = phys(head_q, pos);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    rev_d       = rev_q;
    err_d       = err_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    out_load    = 1'b0;
    out_elem_d  = '0;
    out_stat_d  = ST_ELEM;
    out_last_d  = 1'b0;
    case (state_q)
      BK_RUN: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            MODE_LOAD: begin
              cmd_ready_o = 1'b1;
              if (cnt_q == CNT_W'(DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            MODE_REV: begin
              cmd_ready_o = 1'b1;
              rev_d       = !rev_q;
            end
            MODE_DEL: begin
              cmd_ready_o = 1'b1;
              if (cnt_q == '0) begin
                err_d = 1'b1;
              end else begin
                if (!rev_q) begin
                  head_d = phys(head_q, PTR_W'(1));
                end
                cnt_d = cnt_m1;
              end
            end
            default: begin
              if (err_q || ovf_q || cnt_q == '0) begin
                if (out_free) begin
                  cmd_ready_o = 1'b1;
                  out_load    = 1'b1;
                  out_last_d  = 1'b1;
                  out_stat_d  = err_q ? ST_ERR : (ovf_q ? ST_OVF : ST_EMPTY);
                  head_d      = '0;
                  cnt_d       = '0;
                  rev_d       = 1'b0;
                  err_d       = 1'b0;
                  ovf_d       = 1'b0;
                end
              end else begin
                cmd_ready_o = 1'b1;
                idx_d       = '0;
                state_d     = BK_READ;
              end
            end
          endcase
        end
      end
      BK_READ: begin
        re      = 1'b1;
        state_d = BK_CAPT;
      end
      BK_CAPT: begin
        // read data holds until the output register frees up
        if (out_free) begin
          out_load   = 1'b1;
          out_elem_d = ELEM_W'(rdata);
          out_last_d = is_last;
          if (is_last) begin
            head_d  = '0;
            cnt_d   = '0;
            rev_d   = 1'b0;
            err_d   = 1'b0;
            ovf_d   = 1'b0;
            state_d = BK_RUN;
          end else begin
            idx_d   = idx_q + PTR_W'(1);
            state_d = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      head_q      <= '0;
      cnt_q       <= '0;
      rev_q       <= 1'b0;
      err_q       <= 1'b0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
      err_q   <= err_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_elem_q <= out_elem_d;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.element = out_elem_q;
  assign out_o.status  = out_stat_q;
  assign out_o.last    = out_last_q;

endmodule

[sim/rdb_drain_checker.sv]
// rdb_drain_checker: watches the command and result channels of reversible_deque_buffer,
// tracks the deque contents and flags itself and compares every drained word
// depends on rdb_pkg and rdb_if
module rdb_drain_checker import rdb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rdb_in_if    cmd_i,
  rdb_out_if   res_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    status_e           status;
    logic              last;
  } drain_word_t;

  drain_word_t           drain_q[$];
  logic [DATA_WIDTH-1:0] shadow [DEPTH];
  int unsigned           head;
  int unsigned           held;
  logic                  rev;
  logic                  err_seen;
  logic                  ovf_seen;
  int                    fail_cnt;
  int                    checked;

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic push_word(input logic [ELEM_W-1:0] element, input status_e status,
                           input logic last);
    drain_word_t w;
    w.element = element;
    w.status  = status;
    w.last    = last;
    drain_q.insert(drain_q.size(), w);
  endtask

  // one command word against the shadow deque
  task automatic apply_command(input mode_e op, input logic [VALUE_W-1:0] v);
    int unsigned pos;
    case (op)
      MODE_LOAD: begin
        if (held >= DEPTH) begin
          ovf_seen = 1'b1;
        end else begin
          shadow[(head + held) % DEPTH] = v[DATA_WIDTH-1:0];
          held++;
        end
      end
      MODE_REV: begin
        rev = ~rev;
      end
      MODE_DEL: begin
        if (held == 0) begin
          err_seen = 1'b1;
        end else begin
          // while reversed the front is the physical back, so only the count shrinks
          if (!rev) head = (head + 1) % DEPTH;
          held--;
        end
      end
      default: begin
        if (err_seen) begin
          push_word('0, ST_ERR, 1'b1);
        end else if (ovf_seen) begin
          push_word('0, ST_OVF, 1'b1);
        end else if (held == 0) begin
          push_word('0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned k = 0; k < held; k++) begin
            pos = rev ? (held - 1 - k) : k;
            push_word(ELEM_W'(shadow[(head + pos) % DEPTH]), ST_ELEM, (k + 1 == held));
          end
        end
        head     = 0;
        held     = 0;
        rev      = 1'b0;
        err_seen = 1'b0;
        ovf_seen = 1'b0;
      end
    endcase
  endtask

  task automatic check_result();
    drain_word_t want;
    if (drain_q.size() == 0) begin
      note_mismatch($sformatf("unexpected word element=%h status=%0d last=%b",
                              res_i.element, res_i.status, res_i.last));
    end else begin
      want = drain_q[0];
      drain_q.delete(0);
      checked++;
      if (res_i.element !== want.element) begin
        note_mismatch($sformatf("element %h, wanted %h", res_i.element, want.element));
      end
      if (res_i.status !== want.status) begin
        note_mismatch($sformatf("status %0d, wanted %0d", res_i.status, want.status));
      end
      if (res_i.last !== want.last) begin
        note_mismatch($sformatf("last %b, wanted %b", res_i.last, want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head     = 0;
      held     = 0;
      rev      = 1'b0;
      err_seen = 1'b0;
      ovf_seen = 1'b0;
      fail_cnt = 0;
      checked  = 0;
      drain_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (cmd_i.valid && cmd_i.ready) apply_command(mode_e'(cmd_i.mode), cmd_i.value);
      mismatches_o <= fail_cnt;
      pending_o    <= drain_q.size();
      checked_o    <= checked;
    end
  end

endmodule

[sim/testbench.sv]
// testbench: drives command words into reversible_deque_buffer with bursty timing
// and a stalling result sink; checking is done by rdb_drain_checker
// depends on rdb_pkg, rdb_if, reversible_deque_buffer and rdb_drain_checker
module testbench;
  import rdb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   pending;
  int   checked;
  int   sent_cnt;
  int   fin_cnt;
  int   fill_cnt;
  int   burst_left;
  int   rx_cycles;
  int   rx_style = 0;
  int   rx_hold = 0;
  logic rx_level = 1'b0;

  rdb_in_if  cmd_w ();
  rdb_out_if res_w ();

  reversible_deque_buffer dut (
    .clk_i,
    .rst_ni,
    .in_i  (cmd_w),
    .out_o (res_w)
  );

  rdb_drain_checker chk (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd_w),
    .res_i        (res_w),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d result words outstanding", pending);
    $display("[reversible_deque_buffer] ERROR");
    $finish;
  end

  // result sink: switches at random among four stall styles
  always @(posedge clk_i) begin
    rx_cycles++;
    if (rx_cycles % 300 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: res_w.ready <= 1'b1;
      1: res_w.ready <= ($urandom_range(0, 1) == 1);
      2: res_w.ready <= ($urandom_range(0, 4) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = $urandom_range(1, 8);
        end
        rx_hold--;
        res_w.ready <= rx_level;
      end
    endcase
  end

  task automatic send_word(input mode_e op, input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_w.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    cmd_w.valid <= 1'b1;
    cmd_w.mode  <= op;
    cmd_w.value <= v;
    @(posedge clk_i);
    while (!cmd_w.ready) @(posedge clk_i);
    burst_left--;
    sent_cnt++;
    if (op == MODE_FIN) fin_cnt++;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'($urandom);
  endfunction

  // hold off until every drained word has come back
  task automatic wait_drained();
    cmd_w.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // short list: mostly loads, some reverses, deletes legal but for a rare one on empty
  task automatic run_list();
    int n;
    int depth;
    int pick;
    n = $urandom_range(0, 14);
    depth = 0;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_word(MODE_LOAD, rand_value());
        depth++;
      end else if (pick < 72) begin
        send_word(MODE_REV, rand_value());
      end else if (depth > 0 || pick >= 97) begin
        send_word(MODE_DEL, rand_value());
        if (depth > 0) depth--;
      end else begin
        send_word(MODE_LOAD, rand_value());
        depth++;
      end
    end
    send_word(MODE_FIN, rand_value());
  endtask

  // full store, optionally with overflow and then delete past empty
  task automatic run_fill(input int kind);
    int pre;
    int rev_at;
    pre = $urandom_range(0, 12);
    // advance the head so the fill wraps round the store
    repeat (pre) send_word(MODE_LOAD, rand_value());
    repeat (pre) send_word(MODE_DEL, rand_value());
    rev_at = $urandom_range(0, DEPTH);
    for (int k = 0; k < DEPTH; k++) begin
      if (k == rev_at) send_word(MODE_REV, rand_value());
      send_word(MODE_LOAD, rand_value());
    end
    if (kind >= 1) repeat ($urandom_range(1, 2)) send_word(MODE_LOAD, rand_value());
    if (kind == 2) repeat (DEPTH + 1) send_word(MODE_DEL, rand_value());
    send_word(MODE_FIN, rand_value());
    fill_cnt++;
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8)) send_word(mode_e'($urandom_range(0, 3)), rand_value());
  endtask

  initial begin
    int seq_no;
    rst_ni      <= 1'b0;
    cmd_w.valid <= 1'b0;
    cmd_w.mode  <= MODE_LOAD;
    cmd_w.value <= '0;
    burst_left  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty finish, delete on empty, load while reversed,
    // delete of the back while reversed, reverse cleared by finish
    send_word(MODE_FIN, 16'h0000);
    send_word(MODE_DEL, 16'hFFFF);
    send_word(MODE_LOAD, 16'h5A5A);
    send_word(MODE_FIN, 16'hFFFF);
    send_word(MODE_LOAD, 16'hFFFF);
    send_word(MODE_LOAD, 16'h0000);
    send_word(MODE_REV, 16'h0000);
    send_word(MODE_LOAD, 16'h1234);
    send_word(MODE_LOAD, 16'h8001);
    send_word(MODE_DEL, 16'h0000);
    send_word(MODE_FIN, 16'h0000);
    send_word(MODE_REV, 16'hFFFF);
    send_word(MODE_FIN, 16'h0000);
    send_word(MODE_LOAD, 16'h00FF);
    send_word(MODE_LOAD, 16'hFF00);
    send_word(MODE_DEL, 16'hFFFF);
    send_word(MODE_REV, 16'h0000);
    send_word(MODE_REV, 16'hFFFF);
    send_word(MODE_FIN, 16'hFFFF);
    send_word(MODE_LOAD, 16'h7FFF);
    send_word(MODE_DEL, 16'h0000);
    send_word(MODE_DEL, 16'h0000);
    send_word(MODE_FIN, 16'h0000);
    wait_drained();

    seq_no = 0;
    while (sent_cnt < 450) begin
      if (seq_no % 6 == 3) begin
        run_fill(fill_cnt % 3);
      end else if (seq_no % 7 == 5) begin
        run_noise();
      end else begin
        run_list();
      end
      if (seq_no % 5 == 4) wait_drained();
      seq_no++;
    end
    // leave the store clean so every expected word can come out
    send_word(MODE_FIN, rand_value());

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("sent %0d command words closing %0d lists (%0d full-store runs)",
             sent_cnt, fin_cnt, fill_cnt);
    $display("checked %0d result words, %0d mismatches", checked, mismatches);
    if (pending != 0) $display("%0d expected result words never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[reversible_deque_buffer] OK");
    end else begin
      $display("[reversible_deque_buffer] ERROR");
    end
    $finish;
  end

endmodule
